// ----- hdl/ffpa_pkg.sv -----
// Shared types and codes for the first-fit pool allocator.
package ffpa_pkg;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;
  localparam logic CFG_POOL_BASE = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [47:0] start;
    logic [32:0] length;
  } seg_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;
    logic shift_down;
    logic shift_up;
    logic wr;
    logic [47:0] wr_start;
    logic [32:0] wr_length;
  } cell_ctl_t;
endpackage

// ----- hdl/first_fit_pool_allocator_core.sv -----
// First-fit pool allocator: top level with the scan sequencer and the cell row.
// Each item scans the segment table one cell per cycle, then may shift the
// tail of the table one place over the row's neighbor links. A free steps
// through scan, decide, an optional shift and done; the input is ready only
// while idle, so a new item is taken only after the last one has finished.
// Writing pool_size rebuilds the table. Results sit in an output register
// while the next item is taken; a finished item waits in the done state
// until the previous result is accepted.
module first_fit_pool_allocator_core import ffpa_pkg::*; #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic command,
  input  logic [31:0] request_size,
  input  logic [47:0] block_address,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [47:0] granted_address,
  output logic [31:0] granted_size,
  output logic [31:0] free_bytes,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [47:0] cfg_data
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DECIDE = 3'd2,
                         S_SHIFT = 3'd3, S_DONE = 3'd4;

  logic [2:0] state;
  logic [47:0] pool_base;
  logic [48:0] pool_end;
  logic [CW-1:0] count;
  logic [32:0] free_total;
  logic cmd;
  logic [32:0] req;
  logic [47:0] addr;
  logic [CW-1:0] idx;
  seg_t prev;
  logic have_prev;
  seg_t cur;
  logic [1:0] res_status;
  logic [47:0] res_addr;
  logic [31:0] res_size;
  seg_t segs [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] sel;
  cell_ctl_t ctl;
  logic [IW-1:0] sel_lo;
  logic sel_ge;
  seg_t load_seg;
  logic [32:0] load_length;
  logic [48:0] clip;

  assign clip = ({17'd0, cfg_data[31:0]} > {1'b0, 48'd0} + (49'h1_0000_0000_0000
                - {1'b0, pool_base})) ? 49'h1_0000_0000_0000 - {1'b0, pool_base}
                : {17'd0, cfg_data[31:0]};
  assign load_seg.start = pool_base;
  assign load_seg.length = load_length;

  assign cur = segs[idx[IW-1:0]];
  assign in_ready = (state == S_IDLE);

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      seg_t up_s, dn_s;
      if (g == 0) begin : g_first
        assign up_s = segs[0];
      end else begin : g_up
        assign up_s = segs[g-1];
      end
      if (g == MAX_SEGMENTS - 1) begin : g_last
        assign dn_s = segs[g];
      end else begin : g_dn
        assign dn_s = segs[g+1];
      end
      assign sel[g] = ctl.wr ? (IW'(g) == sel_lo)
                      : (sel_ge ? (g >= int'(sel_lo)) : 1'b0);
      ffpa_cell u_cell (.clk, .sel(sel[g]), .ctl, .up_in(up_s), .dn_in(dn_s),
                        .load_in(load_seg), .seg(segs[g]));
    end
  endgenerate

  logic [48:0] prev_end, blk_end;
  logic [33:0] need;
  assign prev_end = {1'b0, prev.start} + {16'd0, prev.length};
  assign blk_end = {1'b0, addr} + {16'd0, req};
  assign need = {1'b0, req} + 34'(HEADER_BYTES);

  logic in_range;
  assign in_range = idx < count;
  logic join_p, join_n;
  assign join_p = have_prev && (prev_end[47:0] == addr) && !prev_end[48];
  assign join_n = in_range && (blk_end == {1'b0, cur.start});

  always_ff @(posedge clk) begin
    ctl <= '0;
    sel_lo <= '0;
    sel_ge <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pool_base <= '0;
      pool_end <= 49'd65536;
      count <= CW'(1);
      free_total <= 33'd65536;
      load_length <= 33'd65536;
      ctl.load <= 1'b1;
      ctl.wr <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_POOL_BASE) begin
          pool_base <= cfg_data;
        end else begin
          pool_end <= {1'b0, pool_base} + clip;
          free_total <= clip[32:0];
          load_length <= clip[32:0];
          count <= (clip == 49'd0) ? CW'(0) : CW'(1);
          ctl.load <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd <= command;
            req <= {1'b0, request_size};
            addr <= block_address;
            idx <= '0;
            have_prev <= 1'b0;
            res_addr <= '0;
            res_size <= '0;
            res_status <= ST_OK;
            if (command == CMD_ALLOC) begin
              if ({1'b0, request_size} > free_total) begin
                res_status <= ST_NOMEM;
                state <= S_DONE;
              end else state <= S_SCAN;
            end else begin
              if (request_size == 32'd0) state <= S_DONE;
              else if (block_address < pool_base ||
                       ({1'b0, block_address} + {17'd0, request_size}) > pool_end) begin
                res_status <= ST_RANGE;
                state <= S_DONE;
              end else state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cmd == CMD_ALLOC) begin
            if (!in_range) begin
              res_status <= ST_NOMEM;
              state <= S_DONE;
            end else if ({1'b0, cur.length} > need) begin
              ctl.wr <= 1'b1;
              sel_lo <= idx[IW-1:0];
              ctl.wr_start <= cur.start;
              ctl.wr_length <= cur.length - req;
              res_addr <= cur.start + 48'(cur.length - req);
              res_size <= req[31:0];
              free_total <= free_total - req;
              state <= S_DONE;
            end else if (cur.length >= req) begin
              res_addr <= cur.start;
              res_size <= cur.length[31:0];
              free_total <= free_total - cur.length;
              ctl.shift_up <= 1'b1;
              sel_ge <= 1'b1;
              sel_lo <= idx[IW-1:0];
              count <= count - CW'(1);
              state <= S_SHIFT;
            end else idx <= idx + CW'(1);
          end else begin
            if (in_range && cur.start <= addr) begin
              prev <= cur;
              have_prev <= 1'b1;
              idx <= idx + CW'(1);
            end else state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if ((have_prev && prev_end > {1'b0, addr}) ||
              (in_range && blk_end > {1'b0, cur.start})) begin
            res_status <= ST_RANGE;
            state <= S_DONE;
          end else if (join_p && join_n) begin
            ctl.wr <= 1'b1;
            sel_lo <= IW'(idx - CW'(1));
            ctl.wr_start <= prev.start;
            ctl.wr_length <= prev.length + req + cur.length;
            free_total <= free_total + req;
            state <= S_SHIFT;
          end else if (join_p) begin
            ctl.wr <= 1'b1;
            sel_lo <= IW'(idx - CW'(1));
            ctl.wr_start <= prev.start;
            ctl.wr_length <= prev.length + req;
            free_total <= free_total + req;
            state <= S_DONE;
          end else if (join_n) begin
            ctl.wr <= 1'b1;
            sel_lo <= idx[IW-1:0];
            ctl.wr_start <= addr;
            ctl.wr_length <= cur.length + req;
            free_total <= free_total + req;
            state <= S_DONE;
          end else if (count >= CW'(MAX_SEGMENTS)) begin
            res_status <= ST_FULL;
            state <= S_DONE;
          end else begin
            ctl.shift_down <= 1'b1;
            sel_ge <= 1'b1;
            sel_lo <= idx[IW-1:0];
            count <= count + CW'(1);
            free_total <= free_total + req;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (cmd == CMD_FREE && !(join_p && join_n)) begin
            ctl.wr <= 1'b1;
            sel_lo <= idx[IW-1:0];
            ctl.wr_start <= addr;
            ctl.wr_length <= req;
          end else if (cmd == CMD_FREE) begin
            ctl.shift_up <= 1'b1;
            sel_ge <= 1'b1;
            sel_lo <= idx[IW-1:0];
            count <= count - CW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid) begin
            status <= res_status;
            granted_address <= res_addr;
            granted_size <= res_size;
            free_bytes <= free_total[31:0];
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/ffpa_cell.sv -----
// One segment entry of the table; shifts to and from its neighbors.
module ffpa_cell import ffpa_pkg::*; (
  input  logic clk,
  input  logic sel,
  input  cell_ctl_t ctl,
  input  seg_t up_in,
  input  seg_t dn_in,
  input  seg_t load_in,
  output seg_t seg
);
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      seg <= load_in;
    end else if (ctl.wr && sel) begin
      seg.start <= ctl.wr_start;
      seg.length <= ctl.wr_length;
    end else if (ctl.shift_down && sel) begin
      seg <= up_in;
    end else if (ctl.shift_up && sel) begin
      seg <= dn_in;
    end
  end
endmodule
